// ===== design/array_linked_list_insert_unit_assert.svh =====
// ----------------------------------------------------------------------------
// array linked list insert unit assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ARRAY_LINKED_LIST_INSERT_UNIT_ASSERT_SVH
`define ARRAY_LINKED_LIST_INSERT_UNIT_ASSERT_SVH

// condition implies expression in the same cycle
`define ALLI_ASSERT_IMP(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// expression holds at every edge out of reset
`define ALLI_ASSERT_HOLDS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== design/alli_pkg.sv =====
// ----------------------------------------------------------------------------
// alli_pkg
// shared sizes, codes and item types of the linked list insert unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package alli_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_WIDTH  = 32;

    localparam int CMD_W       = 2;
    localparam int POS_W       = 6;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 6;
    localparam int STATUS_W    = 2;

    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int STORE_W     = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT_AFTER = 2'd2;

    typedef enum logic [1:0] {
        KIND_BACK,
        KIND_FRONT,
        KIND_AFTER,
        KIND_BAD
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        kind_t               kind;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  value;
    } alli_item_t;

    typedef struct packed {
        logic        valid;
        alli_item_t  item;
    } alli_push_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } alli_back_stat_t;

endpackage

// ===== design/alli_front.sv =====
// ----------------------------------------------------------------------------
// alli_front
// takes input transactions and classifies the command for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alli_front
    import alli_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // position, value, zero pad
    input  logic [CMD_W-1:0]      s_tuser,   // cmd
    output alli_push_t            push,
    input  logic                  push_ready
);

    kind_t kind;

    always_comb
    begin
        case (s_tuser)
            CMD_PUSH_BACK:    kind = KIND_BACK;
            CMD_PUSH_FRONT:   kind = KIND_FRONT;
            CMD_INSERT_AFTER: kind = KIND_AFTER;
            default:          kind = KIND_BAD;
        endcase
    end

    assign push.valid         = s_tvalid;
    assign push.item.kind     = kind;
    assign push.item.position = s_tdata[POS_W-1:0];
    assign push.item.value    = s_tdata[POS_W+VALUE_W-1:POS_W];
    assign s_tready           = push_ready;

endmodule

// ===== design/alli_queue.sv =====
// ----------------------------------------------------------------------------
// alli_queue
// two entry queue between the classifying front and the list back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alli_queue
    import alli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alli_push_t  push,
    output logic        push_ready,
    output logic        head_valid,
    output alli_item_t  head,
    input  logic        pop
);

    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    alli_item_t        store_reg [QDEPTH];
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QDEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = store_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// ===== design/alli_back.sv =====
// ----------------------------------------------------------------------------
// alli_back
// checks each request against the list, splices in the new slot and
// holds the result transaction until the receiver takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alli_back
    import alli_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  alli_item_t            head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // new slot, zero pad
    output logic [STATUS_W-1:0]   m_tuser,   // status
    output alli_back_stat_t       stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LINK
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   tail_reg;
    logic [IDX_W-1:0]   tail_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic [INDEX_W-1:0] out_index_next;
    status_t            out_status_reg;
    status_t            out_status_next;

    logic [IDX_W-1:0]   link_mem [CAPACITY];
    logic [IDX_W-1:0]   link_rdata_reg;
    logic [STORE_W-1:0] data_mem [CAPACITY];

    logic               out_free;
    logic               full;
    logic [IDX_W-1:0]   slot;
    logic [IDX_W-1:0]   req_pos;
    logic               pos_ok;
    logic [IDX_W-1:0]   after;
    logic               accept_insert;
    logic               link_we;
    logic [IDX_W-1:0]   link_waddr;
    logic [IDX_W-1:0]   link_wdata;

    // slots are handed out in order, so the fill count names the free slot
    assign slot     = count_reg[IDX_W-1:0];
    assign full     = (count_reg >= CNT_W'(CAPACITY));
    assign out_free = !out_valid_reg || m_tready;
    assign after    = (pos_reg == '0) ? head_reg : link_rdata_reg;

    always_comb
    begin
        case (head.kind)
            KIND_BACK:
            begin
                req_pos = tail_reg;
                pos_ok  = 1'b1;
            end
            KIND_FRONT:
            begin
                req_pos = '0;
                pos_ok  = 1'b1;
            end
            KIND_AFTER:
            begin
                req_pos = IDX_W'(head.position);
                pos_ok  = (CMP_W'(head.position) < CMP_W'(count_reg));
            end
            default:
            begin
                req_pos = '0;
                pos_ok  = 1'b0;
            end
        endcase
    end

    assign accept_insert = (state_reg == ST_IDLE) && head_valid && pos_ok && !full;
    assign pop           = accept_insert ||
                           ((state_reg == ST_IDLE) && head_valid && out_free);

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = slot;
        link_wdata = after;
        case (state_reg)
            ST_READ:
            begin
                link_we = 1'b1;
            end
            ST_LINK:
            begin
                link_we    = out_free && (pos_reg != '0);
                link_waddr = pos_reg;
                link_wdata = slot;
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (!pos_ok)
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_index_next  = '0;
                            out_status_next = STATUS_BAD_POS;
                        end
                    end
                    else if (full)
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_index_next  = '0;
                            out_status_next = STATUS_FULL;
                        end
                    end
                    else
                    begin
                        pos_next   = req_pos;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (after == '0)
                begin
                    tail_next = slot;
                end
                state_next = ST_LINK;
            end
            ST_LINK:
            begin
                if (out_free)
                begin
                    if (pos_reg == '0)
                    begin
                        head_next = slot;
                    end
                    count_next      = count_reg + 1'b1;
                    out_valid_next  = 1'b1;
                    out_index_next  = INDEX_W'(slot);
                    out_status_next = STATUS_OK;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= CNT_W'(1);
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            out_index_reg  <= out_index_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[req_pos];
    end

    always_ff @(posedge clk)
    begin
        if (accept_insert)
        begin
            data_mem[slot] <= head.value[STORE_W-1:0];
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = M_TDATA_W'(out_index_reg);
    assign m_tuser    = out_status_reg;
    assign stat.count = count_reg;

endmodule

// ===== design/array_linked_list_insert_unit.sv =====
// ----------------------------------------------------------------------------
// array_linked_list_insert_unit
// insert-only singly linked list in fixed link storage with a sentinel slot
//
// the slave channel carries one request per transaction: push back, push
// front or insert after a slot, with a data word. the master channel returns
// one result per request: the new slot, or zero with a reject status.
// a request is taken into a two entry queue, so s_tready only drops when the
// queue is full. a successful insert reads the anchor's next link, writes it
// into the new slot's link, then links the anchor to the new slot and returns
// the result; the back end takes no new request until that insert is done.
// a rejected request is answered from the idle state without touching the
// link memory.
// while m_tready is low the result is held and the next result waits in the
// back end; the queue keeps taking requests until it fills.
// reset empties the list: only the sentinel is in use and slot 1 is next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "array_linked_list_insert_unit_assert.svh"

module array_linked_list_insert_unit
    import alli_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // position, value, zero pad
    input  logic [CMD_W-1:0]      s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // new slot, zero pad
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    alli_push_t      push;
    logic            push_ready;
    logic            head_valid;
    alli_item_t      head;
    logic            pop;
    alli_back_stat_t back_stat;

    alli_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_ready (push_ready)
    );

    alli_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    alli_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .stat       (back_stat)
    )
    ;

    `ALLI_ASSERT_IMP(a_ok_has_slot, m_tvalid && (m_tuser == STATUS_OK), m_tdata != '0, "ok result with slot zero")
    `ALLI_ASSERT_IMP(a_reject_no_slot, m_tvalid && (m_tuser != STATUS_OK), m_tdata == '0, "reject result with a slot")
    `ALLI_ASSERT_HOLDS(a_count_bound, back_stat.count <= CNT_W'(CAPACITY), "element count above capacity")
    `ALLI_ASSERT_IMP(a_count_step, back_stat.count != $past(back_stat.count), m_tvalid && (m_tuser == STATUS_OK), "count moved without an ok result")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for array_linked_list_insert_unit
// drives push back, push front, insert-after and unknown-command requests over the slave
// stream, tracks the link arrays and free list alongside the unit, and checks
// the new slot and status of every result on the master stream. both sides
// idle at random, and the receiver holds off for long stretches so the
// request queue fills and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import alli_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int NUM_RANDOM = 1680;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 300;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        int unsigned        gap;
    } insert_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] new_slot;
        status_t            status;
    } insert_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // position, value, zero pad
    logic [CMD_W-1:0]     s_tuser = '0;    // cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // new slot, zero pad
    logic [STATUS_W-1:0]  m_tuser;         // status

    insert_req_t    pending_reqs[$];
    insert_result_t results_due[$];
    insert_req_t    req_on_bus;

    // shadow of the list held by the unit
    logic [IDX_W-1:0] link_next[CAPACITY];
    logic [IDX_W-1:0] link_prev[CAPACITY];
    bit               slot_used[CAPACITY];
    logic [IDX_W-1:0] free_slot;
    int               live_count;

    int          err_count = 0;
    int          results_seen = 0;
    int          gen_count;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int          hold_mark = -1;
    int          idle_cycles = 0;

    array_linked_list_insert_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch on result %0d: %s expected %0d got %0d",
                 results_seen, what, want, got);
        err_count++;
    endtask

    function automatic insert_result_t predict_insert(insert_req_t req);
        insert_result_t   res;
        logic [IDX_W-1:0] anchor;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] follower;
        res.new_slot  = '0;
        res.status    = STATUS_OK;
        anchor        = '0;
        case (req.cmd)
            CMD_PUSH_BACK:    anchor = link_prev[0];
            CMD_PUSH_FRONT:   anchor = '0;
            CMD_INSERT_AFTER:
            begin
                if (int'(req.position) >= CAPACITY || !slot_used[req.position])
                    res.status = STATUS_BAD_POS;
                else
                    anchor = req.position;
            end
            default:          res.status = STATUS_BAD_POS;
        endcase
        if (res.status == STATUS_OK && live_count >= CAPACITY)
            res.status = STATUS_FULL;
        if (res.status == STATUS_OK)
        begin
            slot              = free_slot;
            free_slot         = link_next[slot];
            live_count++;
            follower          = link_next[anchor];
            link_prev[follower] = slot;
            link_next[slot]   = follower;
            link_next[anchor] = slot;
            link_prev[slot]   = anchor;
            slot_used[slot]   = 1'b1;
            res.new_slot      = INDEX_W'(slot);
        end
        return res;
    endfunction

    task automatic queue_request(input logic [CMD_W-1:0] cmd,
                                 input logic [POS_W-1:0] position,
                                 input logic [VALUE_W-1:0] value);
        insert_req_t req;
        int unsigned roll;
        req.cmd      = cmd;
        req.position = position;
        req.value    = value;
        roll         = $urandom_range(0, 99);
        if (pending_reqs.size() >= 600 && pending_reqs.size() < 800)
            req.gap = 0;
        else if (roll < 60)
            req.gap = 0;
        else if (roll < 90)
            req.gap = $urandom_range(1, 3);
        else
            req.gap = $urandom_range(5, 30);
        if (gen_count < CAPACITY && (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT
            || (cmd == CMD_INSERT_AFTER && int'(position) < gen_count)))
            gen_count++;
        pending_reqs.push_back(req);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                results_due.push_back(predict_insert(req_on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req_on_bus = pending_reqs.pop_front();
                    s_tdata  <= {2'b00, req_on_bus.value, req_on_bus.position};
                    s_tuser  <= req_on_bus.cmd;
                    s_tvalid <= 1'b1;
                    send_gap <= pending_reqs.size() > 0 ? pending_reqs[0].gap : 0;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        insert_result_t want;
        int unsigned    roll;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected transaction, new slot", 0,
                                    32'(m_tdata[INDEX_W-1:0]));
                else
                begin
                    want = results_due.pop_front();
                    if (m_tdata[INDEX_W-1:0] !== want.new_slot)
                        report_mismatch("new slot", 32'(want.new_slot),
                                        32'(m_tdata[INDEX_W-1:0]));
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(m_tuser));
                end
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (results_seen != hold_mark
                     && (results_seen == 300 || results_seen == 1200))
            begin
                hold_mark = results_seen;
                hold_left <= HOLD_LEN;
                m_tready  <= 1'b0;
            end
            else if (results_seen >= 800 && results_seen < 1000)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    m_tready <= 1'b1;
                else if (roll < 90)
                begin
                    stall_left <= $urandom_range(0, 2);
                    m_tready   <= 1'b0;
                end
                else
                begin
                    stall_left <= $urandom_range(4, 25);
                    m_tready   <= 1'b0;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        int unsigned        roll;

        for (int i = 0; i < CAPACITY; i++)
        begin
            link_next[i] = IDX_W'(i + 1);
            link_prev[i] = '0;
            slot_used[i] = 1'b0;
        end
        link_next[0]            = '0;
        link_next[CAPACITY - 1] = '0;
        slot_used[0]            = 1'b1;
        free_slot               = IDX_W'(1);
        live_count              = 1;
        gen_count               = 1;

        // directed: unused slots, unknown command, every operation, extremes
        queue_request(CMD_INSERT_AFTER, 6'd1, 32'h0000_0001);
        queue_request(CMD_UNKNOWN, 6'd0, 32'h0000_0000);
        queue_request(CMD_UNKNOWN, 6'd63, 32'hffff_ffff);
        queue_request(CMD_PUSH_BACK, 6'd63, 32'h0000_0000);
        queue_request(CMD_PUSH_BACK, 6'd0, 32'hffff_ffff);
        queue_request(CMD_PUSH_FRONT, 6'd42, 32'ha5a5_a5a5);
        queue_request(CMD_INSERT_AFTER, 6'd0, 32'h5a5a_5a5a);
        queue_request(CMD_INSERT_AFTER, 6'd2, 32'h8000_0000);
        queue_request(CMD_INSERT_AFTER, 6'd1, 32'h7fff_ffff);
        queue_request(CMD_INSERT_AFTER, 6'd63, 32'h1234_5678);
        queue_request(CMD_INSERT_AFTER, 6'd7, 32'h0000_00ff);
        queue_request(CMD_INSERT_AFTER, 6'd32, 32'hdead_beef);
        queue_request(CMD_PUSH_FRONT, 6'd21, 32'h0000_0000);
        queue_request(CMD_PUSH_BACK, 6'd10, 32'hffff_ffff);
        queue_request(CMD_INSERT_AFTER, 6'd6, 32'hcafe_f00d);
        queue_request(CMD_INSERT_AFTER, 6'd10, 32'h0f0f_0f0f);
        queue_request(CMD_UNKNOWN, 6'd5, 32'hf0f0_f0f0);
        queue_request(CMD_PUSH_BACK, 6'd0, 32'h0000_0001);
        queue_request(CMD_INSERT_AFTER, 6'd20, 32'h0000_0002);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            roll     = $urandom_range(0, 99);
            position = POS_W'($urandom_range(0, 63));
            if (roll < 40)
                cmd = CMD_PUSH_BACK;
            else if (roll < 60)
                cmd = CMD_PUSH_FRONT;
            else if (roll < 95)
            begin
                cmd = CMD_INSERT_AFTER;
                if ($urandom_range(0, 99) < 85)
                    position = POS_W'($urandom_range(0, gen_count - 1));
            end
            else
                cmd = CMD_UNKNOWN;
            roll = $urandom_range(0, 9);
            if (roll == 0)
                value = '0;
            else if (roll == 1)
                value = '1;
            else
                value = $urandom;
            queue_request(cmd, position, value);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
